/* hdl/iss_pkg.sv */
// Shared constants and types for the insertion sorter.
package iss_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_op_t;

endpackage

/* hdl/iss_cell.sv */
// One sorter cell: holds one entry, inserts on compare, shifts down on drain.
module iss_cell
  import iss_pkg::*;
(
  input  logic                     clk_i,
  input  cell_op_t                 op_i,
  input  logic signed [DATA_W-1:0] key_i,
  input  logic                     occ_i,
  input  logic                     prev_occ_i,
  input  logic                     prev_gt_i,
  input  logic signed [DATA_W-1:0] prev_val_i,
  input  logic signed [DATA_W-1:0] next_val_i,
  output logic signed [DATA_W-1:0] val_o,
  output logic                     gt_o
);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     gt;
  logic                     take;

  // strictly greater keeps equal keys below the new one
  assign gt   = val_q > key_i;
  assign take = op_i.insert & (occ_i ? gt : prev_occ_i);

  always_comb begin
    val_d = val_q;
    if (take) begin
      // move the neighbor up if it is also greater, else the key lands here
      val_d = (prev_occ_i & prev_gt_i) ? prev_val_i : key_i;
    end else if (op_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign gt_o  = gt;

endmodule

/* hdl/iss_ctrl.sv */
// Load/drain sequencer with fill count and overflow flag.
module iss_ctrl
  import iss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_last_o,
  output logic             out_dropped_o,
  output cell_op_t         op_o,
  output logic [CNT_W-1:0] fill_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic             accept;
  logic             full;
  logic             drain_end;

  assign full      = fill_q == CNT_W'(DEPTH);
  assign accept    = in_valid_i & in_ready_o;
  assign drain_end = out_valid_o & out_ready_i & out_last_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (accept && in_last_i) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_end) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD:  in_ready_o  = 1'b1;
      ST_DRAIN: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign out_last_o    = fill_q == CNT_W'(1);
  assign out_dropped_o = ovf_q;
  assign op_o.insert   = accept & ~full;
  assign op_o.shift    = out_valid_o & out_ready_i;

  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    if (op_o.insert) fill_d = fill_q + CNT_W'(1);
    if (op_o.shift)  fill_d = fill_q - CNT_W'(1);
    // drop the item into a full store, remember for the whole batch
    if (accept && full) ovf_d = 1'b1;
    if (drain_end)      ovf_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
    end
  end

  assign fill_o = fill_q;

endmodule

/* hdl/insertion_sorter_unit.sv */
// The first result is valid in the cycle after the last item of a batch is accepted.
// Throughput: one input item per cycle while loading, one result per cycle while draining and m_axis_tready_i is high.
// A batch of N stored values drains as N results; input is held off during the drain.
// Each item is inserted by the cell row, all cells comparing at once.
// Reset clears the sequencer, fill count and overflow flag; cell contents are not reset.
module insertion_sorter_unit
  import iss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic              s_axis_tlast_i,  // batch_end
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,  // [31:0] sorted_value
  output logic              m_axis_tlast_o,  // final_res
  output logic              m_axis_tuser_o   // [0] dropped
);

  cell_op_t                 op;
  logic [CNT_W-1:0]         fill;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] val      [DEPTH];
  logic                     gt       [DEPTH];
  logic                     occ      [DEPTH];
  logic signed [DATA_W-1:0] prev_val [DEPTH];
  logic signed [DATA_W-1:0] next_val [DEPTH];
  logic                     prev_gt  [DEPTH];
  logic                     prev_occ [DEPTH];

  assign key = $signed(s_axis_tdata_i);

  iss_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_last_i     (s_axis_tlast_i),
    .in_ready_o    (s_axis_tready_o),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_last_o    (m_axis_tlast_o),
    .out_dropped_o (m_axis_tuser_o),
    .op_o          (op),
    .fill_o        (fill)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = CNT_W'(i) < fill;

    if (i == 0) begin : g_first
      assign prev_occ[i] = 1'b1;
      assign prev_gt[i]  = 1'b0;
      assign prev_val[i] = key;
    end else begin : g_mid
      assign prev_occ[i] = occ[i-1];
      assign prev_gt[i]  = gt[i-1];
      assign prev_val[i] = val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val[i] = val[i];
    end else begin : g_inner
      assign next_val[i] = val[i+1];
    end

    iss_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .key_i      (key),
      .occ_i      (occ[i]),
      .prev_occ_i (prev_occ[i]),
      .prev_gt_i  (prev_gt[i]),
      .prev_val_i (prev_val[i]),
      .next_val_i (next_val[i]),
      .val_o      (val[i]),
      .gt_o       (gt[i])
    );
  end

  assign m_axis_tdata_o = val[0];

endmodule

/* hdl/iss_checker.sv */
// Port-level checks on load/drain sequencing of the insertion sorter.
module iss_checker
  import iss_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              s_axis_tlast_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic              m_axis_tlast_o,
  input logic              m_axis_tuser_o
);

  // loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while results pending");

  // a closed batch starts draining next cycle
  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("no result after batch end");

  // the final result returns the block to loading
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o)
      |=> (!m_axis_tvalid_o && s_axis_tready_o))
    else $error("drain did not end after final result");

  // the dropped flag holds across one batch
  a_dropped_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o)
      |=> (m_axis_tvalid_o && $stable(m_axis_tuser_o)))
    else $error("batch ended early or dropped flag changed");

endmodule

bind insertion_sorter_unit iss_checker u_iss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
